>>> rtl/ssdfd_pkg.sv
// Shared types, constants and glyph lookup for the seven-segment frame driver.
package ssdfd_pkg;

    // Display geometry
    localparam int DIGIT_COUNT = 4;
    localparam int K_W         = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    // Controller command bytes
    localparam logic [7:0] CMD_DATA = 8'h44;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_DISP = 8'h88;
    localparam logic [7:0] SEG_DOT  = 8'h80;

    // Divide-by-ten reciprocal, exact for every 16-bit value
    localparam logic [31:0] RECIP_10 = 32'd52429;
    localparam int          RECIP_SH = 19;

    // Job queue geometry
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_NUMBER = 2'd0,
        OP_GLYPH  = 2'd1,
        OP_RAW    = 2'd2,
        OP_OFF    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_DATA  = 2'd1,
        SYM_STOP  = 2'd2
    } sym_kind_t;

    // Ten symbols of one digit write
    typedef enum logic [3:0] {
        ST_DSTART = 4'd0,
        ST_DCMD   = 4'd1,
        ST_DSTOP  = 4'd2,
        ST_ASTART = 4'd3,
        ST_ADDR   = 4'd4,
        ST_SEG    = 4'd5,
        ST_ASTOP  = 4'd6,
        ST_BSTART = 4'd7,
        ST_BRIGHT = 4'd8,
        ST_BSTOP  = 4'd9
    } step_t;

    // One digit write: address byte, segment byte, end of request
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] seg;
        logic       last;
    } job_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
    } q_wr_status_t;

    // Queue head seen by the back end
    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

    function automatic logic [7:0] glyph_lookup(input logic [3:0] idx);
        logic [7:0] seg;
        case (idx)
            4'h0:    seg = 8'h3F;
            4'h1:    seg = 8'h06;
            4'h2:    seg = 8'h5B;
            4'h3:    seg = 8'h4F;
            4'h4:    seg = 8'h66;
            4'h5:    seg = 8'h6D;
            4'h6:    seg = 8'h7D;
            4'h7:    seg = 8'h07;
            4'h8:    seg = 8'h7F;
            4'h9:    seg = 8'h6F;
            4'hA:    seg = 8'h77;
            4'hB:    seg = 8'h7C;
            4'hC:    seg = 8'h39;
            4'hD:    seg = 8'h5E;
            4'hE:    seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/ssdfd_front.sv
// Front end: accepts requests and breaks them into digit-write jobs.
module ssdfd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             operation,
    input  logic [15:0]            number,
    input  logic                   blank_leading,
    input  logic [3:0]             dp_mask,
    input  logic [1:0]             position,
    input  logic [7:0]             glyph,
    input  logic                   dot,
    input  logic [7:0]             raw_segments,
    input  ssdfd_pkg::q_wr_status_t q_status,
    output logic                   push,
    output ssdfd_pkg::job_t        push_job
);
    import ssdfd_pkg::*;

    logic           busy_reg, busy_next;
    op_t            op_reg;
    logic [15:0]    rest_reg;
    logic           blank_reg;
    logic [3:0]     dmask_reg;
    logic [1:0]     pos_reg;
    logic [7:0]     glyph_reg;
    logic           dot_reg;
    logic [7:0]     raw_reg;
    logic [K_W-1:0] k_reg;

    logic           accept;
    logic           job_last;
    logic [31:0]    prod;
    logic [15:0]    quot;
    logic [15:0]    quot_x10;
    logic [3:0]     digit;
    logic           leading;
    logic [7:0]     dot_seg;
    logic [7:0]     num_seg;
    logic [7:0]     pos_byte;

    // Split off the low decimal digit by reciprocal multiply
    assign prod     = 32'(rest_reg) * RECIP_10;
    assign quot     = 16'(prod >> RECIP_SH);
    assign quot_x10 = 16'(quot << 3) + 16'(quot << 1);
    assign digit    = 4'(rest_reg - quot_x10);

    // Classify the current digit of number mode
    assign leading = (k_reg != '0) && (rest_reg == 16'd0);
    assign dot_seg = dmask_reg[0] ? SEG_DOT : 8'h00;
    assign num_seg = leading ? (blank_reg ? 8'h00 : (glyph_lookup(4'd0) | dot_seg))
                             : (glyph_lookup(digit) | dot_seg);

    assign job_last = (op_reg == OP_GLYPH) || (op_reg == OP_RAW)
                   || (k_reg == K_W'(DIGIT_COUNT - 1));

    // Build the job for the current position
    always_comb
    begin
        case (op_reg)
            OP_NUMBER:
            begin
                pos_byte     = 8'(DIGIT_COUNT - 1) - 8'(k_reg);
                push_job.seg = num_seg;
            end
            OP_GLYPH:
            begin
                pos_byte     = {6'd0, pos_reg};
                push_job.seg = (glyph_reg[7:4] != 4'd0) ? 8'h00
                             : (glyph_lookup(glyph_reg[3:0]) | (dot_reg ? SEG_DOT : 8'h00));
            end
            OP_RAW:
            begin
                pos_byte     = {6'd0, pos_reg};
                push_job.seg = raw_reg;
            end
            default:
            begin
                pos_byte     = 8'(k_reg);
                push_job.seg = 8'h00;
            end
        endcase
        push_job.addr = CMD_ADDR | pos_byte;
        push_job.last = job_last;
    end

    assign push     = busy_reg && !q_status.full;
    assign in_stall = busy_reg && !(push && job_last);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (push && job_last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // Load a new request, or advance to the next digit on push
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(operation);
            rest_reg  <= number;
            blank_reg <= blank_leading;
            dmask_reg <= dp_mask;
            pos_reg   <= position;
            glyph_reg <= glyph;
            dot_reg   <= dot;
            raw_reg   <= raw_segments;
            k_reg     <= '0;
        end
        else if (push)
        begin
            rest_reg  <= quot;
            dmask_reg <= {1'b0, dmask_reg[3:1]};
            k_reg     <= k_reg + K_W'(1);
        end
    end

endmodule

>>> rtl/ssdfd_queue.sv
// Short job queue between front and back ends.
module ssdfd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ssdfd_pkg::job_t         push_job,
    output ssdfd_pkg::q_wr_status_t q_status,
    input  logic                    pop,
    output ssdfd_pkg::q_head_t      head
);
    import ssdfd_pkg::*;

    job_t            mem [QDEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign q_status.full = (count_reg == QC_W'(QDEPTH));
    assign head.valid    = (count_reg != '0);
    assign head.job      = mem[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QA_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QA_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QC_W'(do_push) - QC_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/ssdfd_back.sv
// Back end: expands each digit-write job into ten controller symbols.
module ssdfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ssdfd_pkg::q_head_t head,
    output logic               pop,
    input  logic [2:0]         brightness,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         symbol_kind,
    output logic [7:0]         byte_value,
    output logic               last_of_run
);
    import ssdfd_pkg::*;

    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    sym_kind_t  kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       load;
    logic       emit;
    sym_kind_t  kind_cur;
    logic [7:0] byte_cur;

    assign load = !out_valid_reg || !out_stall;
    assign emit = load && head.valid;
    assign pop  = emit && (step_reg == ST_BSTOP);

    // Select symbol for the current step and advance the sequencer
    always_comb
    begin
        step_next = step_reg;
        byte_cur  = 8'h00;
        case (step_reg)
            ST_DSTART: begin kind_cur = SYM_START; step_next = ST_DCMD;   end
            ST_DCMD:
            begin
                kind_cur  = SYM_DATA;
                byte_cur  = CMD_DATA;
                step_next = ST_DSTOP;
            end
            ST_DSTOP:  begin kind_cur = SYM_STOP;  step_next = ST_ASTART; end
            ST_ASTART: begin kind_cur = SYM_START; step_next = ST_ADDR;   end
            ST_ADDR:
            begin
                kind_cur  = SYM_DATA;
                byte_cur  = head.job.addr;
                step_next = ST_SEG;
            end
            ST_SEG:
            begin
                kind_cur  = SYM_DATA;
                byte_cur  = head.job.seg;
                step_next = ST_ASTOP;
            end
            ST_ASTOP:  begin kind_cur = SYM_STOP;  step_next = ST_BSTART; end
            ST_BSTART: begin kind_cur = SYM_START; step_next = ST_BRIGHT; end
            ST_BRIGHT:
            begin
                kind_cur  = SYM_DATA;
                byte_cur  = CMD_DISP | {5'd0, brightness};
                step_next = ST_BSTOP;
            end
            ST_BSTOP:  begin kind_cur = SYM_STOP;  step_next = ST_DSTART; end
            default:   begin kind_cur = SYM_START; step_next = ST_DSTART; end
        endcase
        if (!emit)
            step_next = step_reg;
        out_valid_next = load ? head.valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_DSTART;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output symbol until it is taken
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_cur;
            byte_reg <= byte_cur;
            last_reg <= head.job.last && (step_reg == ST_BSTOP);
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_kind = kind_reg;
    assign byte_value  = byte_reg;
    assign last_of_run = last_reg;

endmodule

>>> rtl/seven_segment_display_frame_driver_top.sv
// A request's first symbol passes the front-end registers, a queue entry and the
// back-end output register. One symbol per cycle leaves while a job is queued and
// out_stall is low; number and all-off requests make 40 symbols, glyph or raw 10.
// Front end queues digit jobs ahead, so the next request is taken while symbols drain.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the output
// valid flag and sets brightness to 7.
module seven_segment_display_frame_driver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] number,
    input  logic        blank_leading,
    input  logic [3:0]  dp_mask,
    input  logic [1:0]  position,
    input  logic [7:0]  glyph,
    input  logic        dot,
    input  logic [7:0]  raw_segments,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  symbol_kind,
    output logic [7:0]  byte_value,
    output logic        last_of_run
);
    import ssdfd_pkg::*;

    logic [2:0]   brightness_reg;
    logic         push;
    job_t         push_job;
    q_wr_status_t q_status;
    logic         pop;
    q_head_t      head;

    // Store brightness; the 3-bit field already caps it at 7
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            brightness_reg <= 3'd7;
        else if (cfg_we)
            brightness_reg <= cfg_wdata;
    end

    ssdfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .number        (number),
        .blank_leading (blank_leading),
        .dp_mask       (dp_mask),
        .position      (position),
        .glyph         (glyph),
        .dot           (dot),
        .raw_segments  (raw_segments),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    ssdfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_status (q_status),
        .pop      (pop),
        .head     (head)
    );

    ssdfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .brightness  (brightness_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol_kind (symbol_kind),
        .byte_value  (byte_value),
        .last_of_run (last_of_run)
    );

endmodule
